// ===== rtl/arvt_pkg.sv =====
`timescale 1ns / 1ps

package arvt_pkg;

   localparam int MaxEntries  = 32;
   localparam int IdBits      = 8;
   localparam int VersionBits = 32;
   localparam int IndexBits   = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
   localparam int CountBits   = $clog2(MaxEntries + 1);
   localparam int EntryBits   = IdBits + VersionBits;

   localparam logic KindCheck = 1'b0;
   localparam logic KindQuery = 1'b1;

   typedef struct packed {
      logic [IdBits-1:0]      ident;
      logic [VersionBits-1:0] version;
   } entry_type;

   typedef enum logic [1:0] {
      StIdle,
      StScan,
      StDecide
   } state_type;

endpackage

// ===== rtl/arvt_if.sv =====
`timescale 1ns / 1ps

interface arvt_req_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [arvt_pkg::IdBits-1:0]      component_id;
   logic [arvt_pkg::VersionBits-1:0] offered_version;

   modport source (output valid, output kind, output component_id,
                   output offered_version, input ready);
   modport sink (input valid, input kind, input component_id,
                 input offered_version, output ready);
endinterface

interface arvt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             accepted;
   logic [arvt_pkg::VersionBits-1:0] previous_version;
   logic                             was_found;
   logic                             stored;

   modport source (output valid, output accepted, output previous_version,
                   output was_found, output stored, input ready);
   modport sink (input valid, input accepted, input previous_version,
                 input was_found, input stored, output ready);
endinterface

// ===== rtl/arvt_ram.sv =====
`timescale 1ns / 1ps

module arvt_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr,
   input  logic [Width-1:0]                             wdata,
   output logic [Width-1:0]                             rdata
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/anti_rollback_version_table_core.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake     Payload
// req      in         valid/ready   kind, component_id, offered_version
// rsp      out        valid/ready   accepted, previous_version, was_found, stored
//
// Each transaction's lookup reads up to entry_count entries through the single
// table RAM port, one entry a cycle from index 0, stopping at the first match.
// A full table holds 32 entries.
// Reset empties the table at once; no clearing pass is needed.
// A finished result waits in the output register while the next transaction
// is accepted and scanned; its table update and result wait for that register to free.

module anti_rollback_version_table_core (
   input logic         clock,
   input logic         reset,
   arvt_req_if.sink    req_chan,
   arvt_rsp_if.source  rsp_chan
);

   arvt_pkg::state_type state_ff, state_in;
   logic [arvt_pkg::CountBits-1:0]   count_ff, count_in;
   logic [arvt_pkg::CountBits-1:0]   issue_ff, issue_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic [arvt_pkg::IndexBits-1:0]   rd_idx_ff, rd_idx_in;
   logic [arvt_pkg::IndexBits-1:0]   hit_idx_ff, hit_idx_in;
   logic                             found_ff, found_in;
   logic [arvt_pkg::VersionBits-1:0] prev_ff, prev_in;
   logic                             kind_ff, kind_in;
   logic [arvt_pkg::IdBits-1:0]      id_ff, id_in;
   logic [arvt_pkg::VersionBits-1:0] cand_ff, cand_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_accepted_ff, rsp_accepted_in;
   logic [arvt_pkg::VersionBits-1:0] rsp_prev_ff, rsp_prev_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic                             rsp_stored_ff, rsp_stored_in;

   logic                             ram_we;
   logic [arvt_pkg::IndexBits-1:0]   ram_addr;
   logic [arvt_pkg::EntryBits-1:0]   ram_wdata;
   logic [arvt_pkg::EntryBits-1:0]   ram_rdata;
   arvt_pkg::entry_type              rd_entry;
   arvt_pkg::entry_type              wr_entry;

   logic hit;
   logic room;
   logic pass;
   logic do_write;
   logic do_append;
   logic rsp_free;

   arvt_ram #(
      .Width (arvt_pkg::EntryBits),
      .Depth (arvt_pkg::MaxEntries)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rd_entry  = arvt_pkg::entry_type'(ram_rdata);
   assign wr_entry  = '{ident: id_ff, version: cand_ff};
   assign ram_wdata = arvt_pkg::EntryBits'(wr_entry);

   assign hit       = rd_vld_ff && (rd_entry.ident == id_ff);
   assign room      = count_ff < arvt_pkg::CountBits'(arvt_pkg::MaxEntries);
   assign pass      = (kind_ff == arvt_pkg::KindCheck) && !(found_ff && (cand_ff < prev_ff));
   assign do_write  = pass && (found_ff || room);
   assign do_append = pass && !found_ff && room;
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      issue_in        = issue_ff;
      rd_vld_in       = rd_vld_ff;
      rd_idx_in       = rd_idx_ff;
      hit_idx_in      = hit_idx_ff;
      found_in        = found_ff;
      prev_in         = prev_ff;
      kind_in         = kind_ff;
      id_in           = id_ff;
      cand_in         = cand_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_prev_in     = rsp_prev_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_stored_in   = rsp_stored_ff;
      ram_we          = 1'b0;
      ram_addr        = issue_ff[arvt_pkg::IndexBits-1:0];
      req_chan.ready  = 1'b0;

      case (state_ff)
         arvt_pkg::StIdle: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               kind_in   = req_chan.kind;
               id_in     = req_chan.component_id;
               cand_in   = req_chan.offered_version;
               issue_in  = '0;
               rd_vld_in = 1'b0;
               found_in  = 1'b0;
               prev_in   = '0;
               state_in  = arvt_pkg::StScan;
            end
         end
         arvt_pkg::StScan: begin
            rd_vld_in = 1'b0;
            if (hit) begin
               found_in   = 1'b1;
               hit_idx_in = rd_idx_ff;
               prev_in    = rd_entry.version;
               state_in   = arvt_pkg::StDecide;
            end else if (issue_ff < count_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[arvt_pkg::IndexBits-1:0];
               issue_in  = issue_ff + arvt_pkg::CountBits'(1);
            end else begin
               state_in = arvt_pkg::StDecide;
            end
         end
         arvt_pkg::StDecide: begin
            ram_addr = found_ff ? hit_idx_ff : count_ff[arvt_pkg::IndexBits-1:0];
            if (rsp_free) begin
               ram_we          = do_write;
               if (do_append) begin
                  count_in = count_ff + arvt_pkg::CountBits'(1);
               end
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = pass;
               rsp_prev_in     = prev_ff;
               rsp_found_in    = found_ff;
               rsp_stored_in   = do_write;
               state_in        = arvt_pkg::StIdle;
            end
         end
         default: begin
            state_in = arvt_pkg::StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arvt_pkg::StIdle;
         count_ff     <= '0;
         issue_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff       <= rd_idx_in;
      hit_idx_ff      <= hit_idx_in;
      found_ff        <= found_in;
      prev_ff         <= prev_in;
      kind_ff         <= kind_in;
      id_ff           <= id_in;
      cand_ff         <= cand_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_prev_ff     <= rsp_prev_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_stored_ff   <= rsp_stored_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.accepted         = rsp_accepted_ff;
   assign rsp_chan.previous_version = rsp_prev_ff;
   assign rsp_chan.was_found        = rsp_found_ff;
   assign rsp_chan.stored           = rsp_stored_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= arvt_pkg::CountBits'(arvt_pkg::MaxEntries))
      else $error("Entry count exceeds the table size.");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arvt_pkg::StDecide && rsp_free && do_append)
      |=> count_ff == $past(count_ff) + arvt_pkg::CountBits'(1))
      else $error("Append did not grow the entry count.");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arvt_pkg::StScan && hit)
      |-> {1'b0, rd_idx_ff} < count_ff)
      else $error("Lookup matched an entry beyond the fill count.");

   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arvt_pkg::StDecide && kind_ff == arvt_pkg::KindQuery) |-> !ram_we)
      else $error("Query transaction wrote the table.");

   a_stored_implies_accepted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arvt_pkg::StDecide && rsp_free)
      |=> rsp_valid_ff && (!rsp_stored_ff || rsp_accepted_ff))
      else $error("Result reports a store without acceptance.");
`endif

endmodule

// ===== verif/anti_rollback_version_table_core_tb.sv =====
`timescale 1ns / 1ps

module anti_rollback_version_table_core_tb;
   import arvt_pkg::*;

   typedef struct {
      logic                   accepted;
      logic [VersionBits-1:0] previous_version;
      logic                   was_found;
      logic                   stored;
   } verdict_type;

   // Mirrors the version table and keeps the verdicts that are still owed by the block.
   class version_ledger;
      int unsigned            count;
      logic [IdBits-1:0]      idents [MaxEntries];
      logic [VersionBits-1:0] versions [MaxEntries];
      verdict_type            pending [$];
      int                     errors;
      int                     seen;
      int                     accepted_count;
      int                     rejected_count;
      int                     query_count;
      int                     overflow_count;

      function int find(logic [IdBits-1:0] ident);
         for (int i = 0; i < count; i++) begin
            if (idents[i] == ident) return i;
         end
         return -1;
      endfunction

      function void record_request(logic kind, logic [IdBits-1:0] ident,
                                   logic [VersionBits-1:0] offered);
         int          slot;
         verdict_type v;
         slot = find(ident);
         v.was_found = (slot >= 0);
         v.previous_version = '0;
         if (slot >= 0) v.previous_version = versions[slot];
         v.accepted = 1'b0;
         v.stored = 1'b0;
         if (kind == KindCheck) begin
            if (v.was_found && offered < v.previous_version) begin
               rejected_count++;
            end else begin
               v.accepted = 1'b1;
               accepted_count++;
               if (v.was_found) begin
                  versions[slot] = offered;
                  v.stored = 1'b1;
               end else if (count < MaxEntries) begin
                  idents[count] = ident;
                  versions[count] = offered;
                  count++;
                  v.stored = 1'b1;
               end else begin
                  overflow_count++;
               end
            end
         end else begin
            query_count++;
         end
         pending.push_back(v);
      endfunction

      function void verify_response(logic accepted, logic [VersionBits-1:0] previous_version,
                                    logic was_found, logic stored);
         verdict_type want;
         if (pending.size() == 0) begin
            $error("Response arrived with no transaction outstanding");
            errors++;
            return;
         end
         want = pending.pop_front();
         seen++;
         if (accepted !== want.accepted) begin
            $error("accepted: expected %0d, actual %0d", want.accepted, accepted);
            errors++;
         end
         if (previous_version !== want.previous_version) begin
            $error("previous_version: expected %0h, actual %0h",
                   want.previous_version, previous_version);
            errors++;
         end
         if (was_found !== want.was_found) begin
            $error("was_found: expected %0d, actual %0d", want.was_found, was_found);
            errors++;
         end
         if (stored !== want.stored) begin
            $error("stored: expected %0d, actual %0d", want.stored, stored);
            errors++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   int            idle_pct = 0;
   int            stall_pct = 0;
   version_ledger ledger = new;

   arvt_req_if req_chan ();
   arvt_rsp_if rsp_chan ();

   anti_rollback_version_table_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            ledger.record_request(req_chan.kind, req_chan.component_id,
                                  req_chan.offered_version);
         if (rsp_chan.valid && rsp_chan.ready)
            ledger.verify_response(rsp_chan.accepted, rsp_chan.previous_version,
                                   rsp_chan.was_found, rsp_chan.stored);
      end
   end

   task automatic send_item(input logic kind, input logic [IdBits-1:0] ident,
                            input logic [VersionBits-1:0] offered);
      if ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_chan.valid <= 1'b1;
      req_chan.kind <= kind;
      req_chan.component_id <= ident;
      req_chan.offered_version <= offered;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Most transactions revisit ids already in the table with versions close to the stored one.
   task automatic send_random();
      logic                   kind;
      logic [IdBits-1:0]      ident;
      logic [VersionBits-1:0] prior;
      logic [VersionBits-1:0] offered;
      int                     slot;
      kind = ($urandom_range(99) < 25) ? KindQuery : KindCheck;
      if (ledger.count > 0 && $urandom_range(99) < 60)
         ident = ledger.idents[$urandom_range(ledger.count - 1)];
      else
         ident = IdBits'($urandom_range(255));
      slot = ledger.find(ident);
      prior = $urandom;
      if (slot >= 0) prior = ledger.versions[slot];
      case ($urandom_range(6))
         0: offered = prior - 1;
         1: offered = prior;
         2: offered = prior + 1;
         3: offered = prior + $urandom_range(1000);
         4: offered = '0;
         5: offered = '1;
         default: offered = $urandom;
      endcase
      send_item(kind, ident, offered);
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.kind <= KindCheck;
      req_chan.component_id <= '0;
      req_chan.offered_version <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_item(KindQuery, 8'h00, 32'h0000_0000);
      send_item(KindCheck, 8'h00, 32'h0000_0000);
      send_item(KindCheck, 8'h00, 32'h0000_0000);
      send_item(KindQuery, 8'h00, 32'hFFFF_FFFF);
      send_item(KindCheck, 8'hFF, 32'hFFFF_FFFF);
      send_item(KindCheck, 8'hFF, 32'hFFFF_FFFE);
      send_item(KindCheck, 8'hFF, 32'h0000_0000);
      send_item(KindCheck, 8'hFF, 32'hFFFF_FFFF);
      send_item(KindQuery, 8'hFF, 32'h0000_0000);
      send_item(KindQuery, 8'h55, 32'hAAAA_AAAA);
      send_item(KindCheck, 8'hAA, 32'h5555_5555);
      send_item(KindCheck, 8'hAA, 32'h5555_5556);
      send_item(KindCheck, 8'h55, 32'hAAAA_AAAA);
      send_item(KindQuery, 8'h55, 32'hFFFF_FFFF);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 21; stall_pct = 21; end
         endcase
         repeat (172) send_random();
      end
      req_chan.valid <= 1'b0;

      while (ledger.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Checked %0d transactions: %0d checks accepted (%0d with the table full),",
               ledger.seen, ledger.accepted_count, ledger.overflow_count);
      $display("%0d rollbacks refused, %0d queries; %0d of %0d ids in use at the end.",
               ledger.rejected_count, ledger.query_count, ledger.count, MaxEntries);
      if (ledger.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timed out with %0d responses outstanding.", ledger.pending.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
